// File: rtl/core/gdo_pkg.sv
// ----------------------------------------------------------------------------
// gdo_pkg
// Shared types, calendar constants and month-length helpers for the
// Gregorian date offset block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdo_pkg;

  localparam int YEAR_BITS   = 14;
  localparam int MONTH_BITS  = 4;
  localparam int DAY_BITS    = 5;
  localparam int MOD_BITS    = 9;

  localparam int YEAR_CYCLE  = 400;
  localparam int CENTURY     = 100;
  localparam int YEAR_MIN    = 1;
  localparam int YEAR_MAX    = 9999;
  localparam int MONTH_JAN   = 1;
  localparam int MONTH_FEB   = 2;
  localparam int MONTH_DEC   = 12;
  localparam int FEB_LEAP    = 29;

  localparam int OUT_W       = 24;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOD  = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  // leap test on the year taken modulo 400
  function automatic logic is_leap(input logic [MOD_BITS-1:0] ymod);
    logic not_century;
    not_century = (ymod != MOD_BITS'(CENTURY)) && (ymod != MOD_BITS'(2 * CENTURY)) &&
                  (ymod != MOD_BITS'(3 * CENTURY));
    return (ymod[1:0] == 2'b00) && not_century;
  endfunction

  function automatic logic [DAY_BITS-1:0] month_days(input logic [MONTH_BITS-1:0] month,
                                                     input logic leap);
    logic [DAY_BITS-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_BITS'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_BITS'(30);
      4'd2:    len = leap ? DAY_BITS'(FEB_LEAP) : DAY_BITS'(28);
      default: len = DAY_BITS'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gregorian_date_offset.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset
// Moves a Gregorian date forward or back by a day count, one month per step
// on a single shared adder.
// ----------------------------------------------------------------------------
// sequence: an accept step, year reduction modulo 400 by repeated subtraction,
//   then the month walk, one month per step, ending once the output is free
// throughput: one item at a time, the next item is taken once the walk ends
// reset: rst synchronous active high clears the sequencer and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_offset #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // start_year, start_month, start_day, offset_days, zero pad
  input  wire logic [((23 + COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // mode
  input  wire logic                                   s_tuser,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // result_year, result_month, result_day, zero pad
  output logic [gdo_pkg::OUT_W-1:0]                   m_tdata,
  // out_of_range
  output logic                                        m_tuser
);

  import gdo_pkg::*;

  localparam int TW = (COUNT_BITS + 2 > 15) ? COUNT_BITS + 2 : 15;
  localparam int YW = (COUNT_BITS > 22) ? COUNT_BITS - 6 : 16;

  state_t state;

  logic [YEAR_BITS-1:0]   in_year;
  logic [MONTH_BITS-1:0]  in_month;
  logic [DAY_BITS-1:0]    in_day;
  logic [COUNT_BITS-1:0]  in_count;
  logic [MONTH_BITS-1:0]  in_month_clamp;

  logic signed [YW-1:0]   year;
  logic [YEAR_BITS-1:0]   ymod;
  logic [MONTH_BITS-1:0]  month;
  logic signed [TW-1:0]   t;

  logic signed [TW-1:0]   add_a;
  logic signed [TW-1:0]   add_b;
  logic signed [TW-1:0]   add_sum;

  logic                   t_neg;
  logic                   sum_neg;
  logic                   jan;
  logic                   dec;
  logic [MOD_BITS-1:0]    ymod_lo;
  logic [MOD_BITS-1:0]    ymod_prev;
  logic [MONTH_BITS-1:0]  month_prev;
  logic [DAY_BITS-1:0]    len_cur;
  logic [DAY_BITS-1:0]    len_prev;
  logic                   walk_done;
  logic                   out_free;
  logic                   out_load;
  logic                   oor;

  logic [YEAR_BITS-1:0]   res_year;
  logic [MONTH_BITS-1:0]  res_month;
  logic [DAY_BITS-1:0]    res_day;

  assign in_year  = s_tdata[13:0];
  assign in_month = s_tdata[17:14];
  assign in_day   = s_tdata[22:18];
  assign in_count = s_tdata[23 +: COUNT_BITS];

  always_comb begin
    if (in_month < MONTH_BITS'(MONTH_JAN)) begin
      in_month_clamp = MONTH_BITS'(MONTH_JAN);
    end else if (in_month > MONTH_BITS'(MONTH_DEC)) begin
      in_month_clamp = MONTH_BITS'(MONTH_DEC);
    end else begin
      in_month_clamp = in_month;
    end
  end

  // month neighbors and lengths
  assign ymod_lo    = ymod[MOD_BITS-1:0];
  assign jan        = (month == MONTH_BITS'(MONTH_JAN));
  assign dec        = (month == MONTH_BITS'(MONTH_DEC));
  assign month_prev = jan ? MONTH_BITS'(MONTH_DEC) : month - MONTH_BITS'(1);
  assign ymod_prev  = !jan ? ymod_lo :
                      (ymod_lo == MOD_BITS'(0)) ? MOD_BITS'(YEAR_CYCLE - 1) :
                      ymod_lo - MOD_BITS'(1);
  assign len_cur    = month_days(month, is_leap(ymod_lo));
  assign len_prev   = month_days(month_prev, is_leap(ymod_prev));
  assign t_neg      = t[TW-1];

  // shared adder
  always_comb begin
    add_a = t;
    add_b = '0;
    unique case (state)
      ST_IDLE: begin
        add_a = TW'(in_day);
        if (s_tuser) begin
          add_b = ~TW'(in_count);
        end else if (in_count > COUNT_BITS'(1)) begin
          add_b = TW'(in_count) - TW'(2);
        end else begin
          add_b = '1;
        end
      end
      ST_MOD: begin
        add_a = TW'(ymod);
        add_b = -TW'(YEAR_CYCLE);
      end
      ST_WALK: begin
        add_a = t;
        add_b = t_neg ? TW'(len_prev) : -TW'(len_cur);
      end
      default: begin
        add_a = t;
        add_b = '0;
      end
    endcase
  end

  assign add_sum   = add_a + add_b;
  assign sum_neg   = add_sum[TW-1];
  assign walk_done = (state == ST_WALK) && !t_neg && sum_neg;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = walk_done && out_free;
  assign s_tready  = (state == ST_IDLE);

  assign oor       = (year < YW'(YEAR_MIN)) || (year > YW'(YEAR_MAX));
  assign res_year  = oor ? '0 : year[YEAR_BITS-1:0];
  assign res_month = oor ? '0 : month;
  assign res_day   = oor ? '0 : t[DAY_BITS-1:0] + DAY_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (sum_neg) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          year  <= YW'(in_year);
          ymod  <= in_year;
          month <= in_month_clamp;
          t     <= add_sum;
        end
      end
      ST_MOD: begin
        if (!sum_neg) begin
          ymod <= add_sum[YEAR_BITS-1:0];
        end
      end
      ST_WALK: begin
        if (t_neg) begin
          t     <= add_sum;
          month <= month_prev;
          ymod  <= YEAR_BITS'(ymod_prev);
          if (jan) begin
            year <= year - YW'(1);
          end
        end else if (!sum_neg) begin
          t <= add_sum;
          if (dec) begin
            month <= MONTH_BITS'(MONTH_JAN);
            year  <= year + YW'(1);
            ymod  <= (ymod_lo == MOD_BITS'(YEAR_CYCLE - 1)) ? '0 : ymod + YEAR_BITS'(1);
          end else begin
            month <= month + MONTH_BITS'(1);
          end
        end
      end
      default: begin
        t <= t;
      end
    endcase
    if (out_load) begin
      m_tdata <= {1'b0, res_day, res_month, res_year};
      m_tuser <= oor;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gdo_checker.sv
// ----------------------------------------------------------------------------
// gdo_checker
// Port-level checks for the Gregorian date offset block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gdo_checker #(
  parameter int COUNT_BITS = 16
) (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   s_tvalid,
  input wire logic                                   s_tready,
  input wire logic [((23 + COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input wire logic                                   s_tuser,
  input wire logic                                   m_tvalid,
  input wire logic                                   m_tready,
  input wire logic [gdo_pkg::OUT_W-1:0]              m_tdata,
  input wire logic                                   m_tuser
);

  import gdo_pkg::*;

  logic [YEAR_BITS-1:0]  chk_year;
  logic [MONTH_BITS-1:0] chk_month;
  logic [DAY_BITS-1:0]   chk_day;
  logic                  in_seen;

  assign chk_year  = m_tdata[13:0];
  assign chk_month = m_tdata[17:14];
  assign chk_day   = m_tdata[22:18];
  assign in_seen   = s_tvalid && s_tready && (s_tdata != '0 || s_tuser || !s_tuser);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item in flight, no accept right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_seen |=> !s_tready)
    else $error("input taken while busy");

  // out of range result carries zero fields
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("out of range result not zero");

  // in-range result has year and month in bounds and a nonzero day
  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> chk_year >= YEAR_BITS'(YEAR_MIN) &&
      chk_year <= YEAR_BITS'(YEAR_MAX) && chk_month >= MONTH_BITS'(MONTH_JAN) &&
      chk_month <= MONTH_BITS'(MONTH_DEC) && chk_day != '0)
    else $error("result date out of bounds");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind gregorian_date_offset gdo_checker #(.COUNT_BITS(COUNT_BITS)) u_gdo_checker (.*);

`default_nettype wire

// File: bench/gregorian_date_offset_test.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset_test
// Drives date queries into the date offset block and checks each result
// against a day-number calculation of the same offset, with random idle
// bursts on both stream sides, two drained pauses, and a no-idle tail.
// ----------------------------------------------------------------------------

module gregorian_date_offset_test;
  import gdo_pkg::*;

  localparam int COUNT_W     = 16;
  localparam int FIELD_W     = YEAR_BITS + MONTH_BITS + DAY_BITS + COUNT_W;
  localparam int IN_W        = ((FIELD_W + 7) / 8) * 8;
  localparam int RES_W       = YEAR_BITS + MONTH_BITS + DAY_BITS;
  localparam int RANDOM_ITEMS = 250;
  localparam int STEADY_ITEMS = 40;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam longint unsigned YEAR_OFFSET = 80000;

  typedef enum bit {
    COUNT_FORWARD = 1'b0,
    COUNT_BACK    = 1'b1
  } count_dir_t;

  typedef struct packed {
    count_dir_t            dir;
    bit [YEAR_BITS-1:0]    year;
    bit [MONTH_BITS-1:0]   month;
    bit [DAY_BITS-1:0]     day;
    bit [COUNT_W-1:0]      count;
    bit                    drain_first;
    bit                    steady;
  } date_query_t;

  typedef struct packed {
    bit [YEAR_BITS-1:0]    year;
    bit [MONTH_BITS-1:0]   month;
    bit [DAY_BITS-1:0]     day;
    bit                    out_of_range;
  } date_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;

  date_query_t queued_queries[$];
  date_t       due_dates[$];
  logic        s_taken;
  logic        steady_phase;
  int          send_gap;
  int          hold_gap;
  int          query_total;
  int          accepted_queries;
  int          forward_queries;
  int          back_queries;
  int          dates_checked;
  int          range_errors_seen;
  int          mismatches;
  int          cycles;

  gregorian_date_offset #(
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic bit leap_year(longint unsigned yr);
    return (yr % 4 == 0) && !((yr % 100 == 0) && (yr % 400 != 0));
  endfunction

  function automatic int unsigned month_length(int unsigned mo, bit leap);
    case (mo)
      4, 6, 9, 11: return 30;
      2:           return leap ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // days since jan 1 of shifted year 1, with dy counted from 1
  function automatic longint unsigned day_number(longint unsigned yr, int unsigned mo,
                                                 int unsigned dy);
    longint unsigned p;
    longint unsigned n;
    p = yr - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < mo; k++) n += month_length(k, leap_year(yr));
    return n + dy;
  endfunction

  function automatic date_t offset_date(date_query_t q);
    longint unsigned n;
    longint unsigned r;
    longint unsigned yr;
    longint unsigned cnt;
    longint unsigned q400;
    longint unsigned q100;
    longint unsigned q4;
    longint unsigned q1;
    int unsigned     mo;
    date_t           res;
    mo = 32'(q.month);
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    cnt = 64'(q.count);
    n = day_number(longint'(q.year) + YEAR_OFFSET, mo, 32'(q.day)) - 1;
    if (q.dir == COUNT_FORWARD) begin
      if (cnt > 1) n += cnt - 1;
    end else begin
      n -= cnt;
    end
    q400 = n / 146097;
    r = n % 146097;
    q100 = r / 36524;
    if (q100 > 3) q100 = 3;
    r -= q100 * 36524;
    q4 = r / 1461;
    r = r % 1461;
    q1 = r / 365;
    if (q1 > 3) q1 = 3;
    r -= q1 * 365;
    yr = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    mo = 1;
    while (r >= month_length(mo, leap_year(yr)) && mo != 12) begin
      r -= month_length(mo, leap_year(yr));
      mo++;
    end
    if (yr < YEAR_OFFSET + YEAR_MIN || yr > YEAR_OFFSET + YEAR_MAX) begin
      res = '0;
      res.out_of_range = 1'b1;
    end else begin
      res.year = YEAR_BITS'(yr - YEAR_OFFSET);
      res.month = MONTH_BITS'(mo);
      res.day = DAY_BITS'(r + 1);
      res.out_of_range = 1'b0;
    end
    return res;
  endfunction

  function automatic date_query_t make_query(count_dir_t dir, int yr, int mo, int dy, int cnt);
    date_query_t q;
    q = '0;
    q.dir = dir;
    q.year = YEAR_BITS'(yr);
    q.month = MONTH_BITS'(mo);
    q.day = DAY_BITS'(dy);
    q.count = COUNT_W'(cnt);
    return q;
  endfunction

  function automatic date_query_t random_query();
    date_query_t q;
    int unsigned pick;
    q = '0;
    q.dir = $urandom_range(0, 1) ? COUNT_BACK : COUNT_FORWARD;
    pick = $urandom_range(0, 99);
    if (pick < 80) q.year = YEAR_BITS'($urandom_range(YEAR_MIN, YEAR_MAX));
    else if (pick < 85) q.year = YEAR_BITS'($urandom_range(YEAR_MIN, YEAR_MIN + 150));
    else if (pick < 90) q.year = YEAR_BITS'($urandom_range(YEAR_MAX - 150, YEAR_MAX));
    else q.year = YEAR_BITS'($urandom_range(0, (1 << YEAR_BITS) - 1));
    q.month = MONTH_BITS'(($urandom_range(0, 9) != 0) ? $urandom_range(MONTH_JAN, MONTH_DEC)
                                          : $urandom_range(0, (1 << MONTH_BITS) - 1));
    q.day = DAY_BITS'(($urandom_range(0, 4) != 0) ? $urandom_range(1, 28)
                                        : $urandom_range(0, (1 << DAY_BITS) - 1));
    pick = $urandom_range(0, 99);
    if (pick < 60) q.count = COUNT_W'($urandom_range(0, 400));
    else if (pick < 85) q.count = COUNT_W'($urandom_range(0, 5000));
    else if (pick < 95) q.count = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
    else q.count = COUNT_W'($urandom_range(0, 3) == 0 ? (1 << COUNT_W) - 1
                                                      : $urandom_range(0, 2));
    return q;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver: one item per handshake, random idle bursts outside the tail
  always @(negedge clk) begin
    date_query_t q;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (queued_queries.size() != 0 &&
                   !(queued_queries[0].drain_first && due_dates.size() != 0)) begin
        if (!queued_queries[0].steady && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 10);
          s_tvalid <= 1'b0;
        end else begin
          q = queued_queries.pop_front();
          if (q.steady) steady_phase = 1'b1;
          s_tdata <= IN_W'({q.count, q.day, q.month, q.year});
          s_tuser <= q.dir;
          s_tvalid <= 1'b1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_gap != 0) begin
      hold_gap = hold_gap - 1;
      m_tready <= 1'b0;
    end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
      hold_gap = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    date_query_t q;
    date_t       want;
    date_t       got;
    s_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        q = '0;
        {q.count, q.day, q.month, q.year} = s_tdata[FIELD_W-1:0];
        q.dir = s_tuser ? COUNT_BACK : COUNT_FORWARD;
        due_dates.push_back(offset_date(q));
        accepted_queries++;
        if (q.dir == COUNT_FORWARD) forward_queries++;
        else back_queries++;
      end
      if (m_tvalid && m_tready) begin
        {got.day, got.month, got.year} = m_tdata[RES_W-1:0];
        got.out_of_range = m_tuser;
        if (due_dates.size() == 0) begin
          $error("result with no query pending: year %0d month %0d day %0d",
                 got.year, got.month, got.day);
          mismatches++;
        end else begin
          want = due_dates.pop_front();
          dates_checked++;
          if (got.out_of_range) range_errors_seen++;
          if (got.year != want.year) begin
            $error("result_year: expected %0d, got %0d", want.year, got.year);
            mismatches++;
          end
          if (got.month != want.month) begin
            $error("result_month: expected %0d, got %0d", want.month, got.month);
            mismatches++;
          end
          if (got.day != want.day) begin
            $error("result_day: expected %0d, got %0d", want.day, got.day);
            mismatches++;
          end
          if (got.out_of_range != want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                   got.out_of_range);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_dates.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    date_query_t q;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    s_taken = 1'b0;
    steady_phase = 1'b0;
    send_gap = 0;
    hold_gap = 0;
    accepted_queries = 0;
    forward_queries = 0;
    back_queries = 0;
    dates_checked = 0;
    range_errors_seen = 0;
    mismatches = 0;
    cycles = 0;

    // directed corners
    queued_queries.push_back(make_query(COUNT_FORWARD, 2024, 1, 1, 0));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2024, 1, 1, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2024, 1, 1, 2));
    queued_queries.push_back(make_query(COUNT_BACK, 2024, 1, 1, 0));
    queued_queries.push_back(make_query(COUNT_BACK, 2024, 3, 1, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 1900, 2, 28, 2));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2000, 2, 28, 2));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2024, 12, 31, 2));
    queued_queries.push_back(make_query(COUNT_BACK, 2000, 1, 1, 366));
    queued_queries.push_back(make_query(COUNT_FORWARD, YEAR_MAX, 12, 31, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, YEAR_MAX, 12, 31, 2));
    queued_queries.push_back(make_query(COUNT_BACK, YEAR_MIN, 1, 1, 0));
    queued_queries.push_back(make_query(COUNT_BACK, YEAR_MIN, 1, 1, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2023, 0, 15, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2023, 15, 15, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2023, 3, 0, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 2023, 2, 31, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 0, 6, 15, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, (1 << YEAR_BITS) - 1, 12, 31, 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, YEAR_MIN, 1, 1, (1 << COUNT_W) - 1));
    queued_queries.push_back(make_query(COUNT_BACK, YEAR_MAX, 12, 31, (1 << COUNT_W) - 1));
    queued_queries.push_back(make_query(COUNT_FORWARD, 9820, 1, 1, (1 << COUNT_W) - 1));
    queued_queries.push_back(make_query(COUNT_BACK, 150, 6, 30, (1 << COUNT_W) - 1));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      q = random_query();
      q.drain_first = (i == 0) || (i == RANDOM_ITEMS / 2);
      q.steady = (i >= RANDOM_ITEMS - STEADY_ITEMS);
      queued_queries.push_back(q);
    end
    query_total = queued_queries.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_queries != query_total || due_dates.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);

    $display("%0d date queries checked: %0d counted forward, %0d counted back",
             dates_checked, forward_queries, back_queries);
    $display("%0d results fell outside years %0d..%0d, %0d mismatches",
             range_errors_seen, YEAR_MIN, YEAR_MAX, mismatches);
    if (mismatches == 0 && due_dates.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/gdo_pkg.sv
rtl/core/gregorian_date_offset.sv
rtl/core/gdo_checker.sv
bench/gregorian_date_offset_test.sv
